[rtl/core/davp_pkg.sv]
// Shared types, constants and helpers for the Diameter AVP stream parser.
// No dependencies; used by every module of the parser core.
package davp_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_PAD     = 2'd2,
        PH_ERROR   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CLS_EAP     = 2'd0,
        CLS_AUTH    = 2'd1,
        CLS_STATE   = 2'd2,
        CLS_UNKNOWN = 2'd3
    } avp_class_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_HDR_TRUNC = 2'd1,
        ST_LEN_SHORT = 2'd2,
        ST_PAY_TRUNC = 2'd3
    } rec_status_t;

    localparam logic [31:0] CODE_EAP   = 32'h0000_004F;
    localparam logic [31:0] CODE_AUTH  = 32'h0000_0050;
    localparam logic [31:0] CODE_STATE = 32'h0000_0018;

    localparam logic [23:0] HDR_BYTES    = 24'd8;
    localparam logic [2:0]  HDR_LAST_IDX = 3'd7;
    localparam logic [2:0]  HDR_CODE_END = 3'd4;  // bytes 0..3 carry the code
    localparam logic [2:0]  HDR_LEN_BEG  = 3'd5;  // bytes 5..7 carry the length

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        avp_class_t  avp_class;
        logic [31:0] avp_code;
        logic        first_of_payload;
        logic        last_of_payload;
        logic        record_done;
        rec_status_t record_status;
    } result_t;

    function automatic avp_class_t class_of(input logic [31:0] code);
        avp_class_t cls;
        priority if (code == CODE_EAP)   cls = CLS_EAP;
        else if     (code == CODE_AUTH)  cls = CLS_AUTH;
        else if     (code == CODE_STATE) cls = CLS_STATE;
        else                             cls = CLS_UNKNOWN;
        return cls;
    endfunction

endpackage

[rtl/core/davp_parse.sv]
// Parse state and per-byte next-state / result logic of the AVP parser.
// Depends on davp_pkg.
module davp_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              beat_accept,
    input  logic [7:0]        data_byte,
    input  logic              last_in_record,
    output logic              res_valid,
    output davp_pkg::result_t res
);
    import davp_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic [2:0]  hdr_idx_reg,  hdr_idx_next;
    logic [31:0] code_reg,     code_next;
    logic [23:0] length_reg,   length_next;
    logic [23:0] pay_left_reg, pay_left_next;
    logic [1:0]  pad_left_reg, pad_left_next;
    rec_status_t err_reg,      err_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            hdr_idx_reg  <= '0;
            code_reg     <= '0;
            length_reg   <= '0;
            pay_left_reg <= '0;
            pad_left_reg <= '0;
            err_reg      <= ST_OK;
        end else begin
            phase_reg    <= phase_next;
            hdr_idx_reg  <= hdr_idx_next;
            code_reg     <= code_next;
            length_reg   <= length_next;
            pay_left_reg <= pay_left_next;
            pad_left_reg <= pad_left_next;
            err_reg      <= err_next;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        code_next     = code_reg;
        length_next   = length_reg;
        pay_left_next = pay_left_reg;
        pad_left_next = pad_left_reg;
        err_next      = err_reg;
        res           = '0;
        res_valid     = 1'b0;

        if (beat_accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (hdr_idx_reg < HDR_CODE_END) begin
                        code_next = {code_reg[23:0], data_byte};
                    end else if (hdr_idx_reg >= HDR_LEN_BEG) begin
                        length_next = {length_reg[15:0], data_byte};
                    end
                    if (hdr_idx_reg == HDR_LAST_IDX) begin
                        hdr_idx_next = '0;
                        if (length_next < HDR_BYTES) begin
                            phase_next = PH_ERROR;
                            err_next   = ST_LEN_SHORT;
                        end else begin
                            pay_left_next = length_next - HDR_BYTES;
                            // padding up to the next 4-byte boundary
                            pad_left_next = (~length_next[1:0]) + 2'd1;
                            priority if (pay_left_next != '0) phase_next = PH_PAYLOAD;
                            else if (pad_left_next != '0)     phase_next = PH_PAD;
                            else                              phase_next = PH_HEADER;
                        end
                    end else begin
                        hdr_idx_next = hdr_idx_reg + 3'd1;
                    end
                end
                PH_PAYLOAD: begin
                    res_valid            = 1'b1;
                    res.payload_valid    = 1'b1;
                    res.payload_byte     = data_byte;
                    res.avp_code         = code_reg;
                    res.avp_class        = class_of(code_reg);
                    res.first_of_payload = (length_reg >= HDR_BYTES) &&
                                           (pay_left_reg == length_reg - HDR_BYTES);
                    if (pay_left_reg != '0) pay_left_next = pay_left_reg - 24'd1;
                    if (pay_left_next == '0) begin
                        res.last_of_payload = 1'b1;
                        phase_next = (pad_left_reg != '0) ? PH_PAD : PH_HEADER;
                    end
                end
                PH_PAD: begin
                    if (pad_left_reg != '0) pad_left_next = pad_left_reg - 2'd1;
                    if (pad_left_next == '0) phase_next = PH_HEADER;
                end
                PH_ERROR: begin
                    // swallow bytes until the record ends
                end
                default: ;
            endcase

            if (last_in_record) begin
                res_valid       = 1'b1;
                res.record_done = 1'b1;
                priority if (phase_next == PH_ERROR)
                    res.record_status = err_next;
                else if (phase_next == PH_HEADER && hdr_idx_next != '0)
                    res.record_status = ST_HDR_TRUNC;
                else if (phase_next == PH_PAYLOAD)
                    res.record_status = ST_PAY_TRUNC;
                else
                    res.record_status = ST_OK;
                // next record starts from a clean parser
                phase_next    = PH_HEADER;
                hdr_idx_next  = '0;
                code_next     = '0;
                length_next   = '0;
                pay_left_next = '0;
                pad_left_next = '0;
                err_next      = ST_OK;
            end
        end
    end

endmodule

[rtl/core/davp_out_reg.sv]
// Result register of the AVP parser: holds one result beat for the m_ side.
// Depends on davp_pkg.
module davp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic              res_valid,
    input  davp_pkg::result_t res,
    input  logic              m_ready,
    output logic              m_valid,
    output logic              can_load,
    output davp_pkg::result_t m_res
);
    import davp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg,  data_next;

    // a new beat may enter when the register is empty or drains this cycle
    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = res_valid;
            data_next  = res;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid = valid_reg;
    assign m_res   = data_reg;

endmodule

[rtl/core/diameter_avp_stream_parser_core.sv]
// Diameter AVP stream parser, top level: one record byte per s_ beat in, one
// tagged payload byte and/or record status per m_ beat out. Depends on davp_pkg,
// davp_parse and davp_out_reg.
//
// Usage: the parser takes one byte every cycle while s_ready is high and gives
// its result in the cycle after acceptance, from a single result register. s_ready
// is high whenever that register is empty or is being read in the same cycle, so
// with m_ready held high the block sustains one byte per clock. Header and padding
// bytes give no beat unless they end the record; a byte marked last always gives one
// beat carrying record_done and the status. The parse counters update on the
// accepted byte itself, so no byte ever waits on another.
module diameter_avp_stream_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_in_record,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_payload_byte,
    output logic        m_payload_valid,
    output logic [1:0]  m_avp_class,
    output logic [31:0] m_avp_code,
    output logic        m_first_of_payload,
    output logic        m_last_of_payload,
    output logic        m_record_done,
    output logic [1:0]  m_record_status
);
    import davp_pkg::*;

    logic    beat_accept;
    logic    res_valid;
    logic    can_load;
    result_t res;
    result_t m_res;

    assign s_ready     = can_load;
    assign beat_accept = s_valid && can_load;

    davp_parse u_parse (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .beat_accept    (beat_accept),
        .data_byte      (s_data_byte),
        .last_in_record (s_last_in_record),
        .res_valid      (res_valid),
        .res            (res)
    );

    davp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (beat_accept),
        .res_valid (res_valid),
        .res       (res),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .can_load  (can_load),
        .m_res     (m_res)
    );

    assign m_payload_byte     = m_res.payload_byte;
    assign m_payload_valid    = m_res.payload_valid;
    assign m_avp_class        = m_res.avp_class;
    assign m_avp_code         = m_res.avp_code;
    assign m_first_of_payload = m_res.first_of_payload;
    assign m_last_of_payload  = m_res.last_of_payload;
    assign m_record_done      = m_res.record_done;
    assign m_record_status    = m_res.record_status;

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while result register empty");

    a_last_gives_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_in_record) |=> (m_valid && m_record_done))
        else $error("record end beat did not produce a closing result");

    a_marks_need_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_first_of_payload || m_last_of_payload)) |-> m_payload_valid)
        else $error("first/last payload mark without payload byte");

    a_status_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_record_status != ST_OK) |-> m_record_done)
        else $error("record status set on a beat that does not close the record");

    a_beat_is_meaningful: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload_valid || m_record_done))
        else $error("empty result beat");
`endif

endmodule

[bench/tb_top.sv]
// Self-checking bench for diameter_avp_stream_parser_core: directed and random
// Diameter records go in byte by byte; every tagged payload/status beat is checked.
// Depends on davp_pkg and the parser core RTL.
module tb_top;
    import davp_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         gap;
        bit         drain;
    } rec_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_in_record = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_payload_byte;
    logic        m_payload_valid;
    logic [1:0]  m_avp_class;
    logic [31:0] m_avp_code;
    logic        m_first_of_payload;
    logic        m_last_of_payload;
    logic        m_record_done;
    logic [1:0]  m_record_status;

    rec_byte_t   tx_bytes[$];
    result_t     expected_beats[$];
    logic [7:0]  rec_buf[$];
    int          fail_cnt = 0;
    int          beat_cnt = 0;
    int          gap_max = 0;
    int          sent_cnt = 0;
    int          tx_total = 0;
    bit          drain_next = 1'b0;
    int          idle_cnt = 0;
    int          stall_left = 0;
    int          stall_draw;
    bit          rx_calm = 1'b0;
    result_t     got;
    result_t     want;

    // shadow copy of the parser state
    phase_t      sh_phase = PH_HEADER;
    logic [2:0]  sh_hidx = '0;
    logic [31:0] sh_code = '0;
    logic [23:0] sh_len = '0;
    logic [23:0] sh_left = '0;
    logic [1:0]  sh_pad = '0;
    rec_status_t sh_err = ST_OK;

    diameter_avp_stream_parser_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_last_in_record   (s_last_in_record),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_payload_byte     (m_payload_byte),
        .m_payload_valid    (m_payload_valid),
        .m_avp_class        (m_avp_class),
        .m_avp_code         (m_avp_code),
        .m_first_of_payload (m_first_of_payload),
        .m_last_of_payload  (m_last_of_payload),
        .m_record_done      (m_record_done),
        .m_record_status    (m_record_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic avp_class_t code_class(input logic [31:0] code);
        case (code)
            CODE_EAP:   return CLS_EAP;
            CODE_AUTH:  return CLS_AUTH;
            CODE_STATE: return CLS_STATE;
            default:    return CLS_UNKNOWN;
        endcase
    endfunction

    task automatic clear_parser();
        sh_phase = PH_HEADER;
        sh_hidx  = '0;
        sh_code  = '0;
        sh_len   = '0;
        sh_left  = '0;
        sh_pad   = '0;
        sh_err   = ST_OK;
    endtask

    // Advance the shadow parser by one accepted byte; queue the beat it causes.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        result_t r;
        r = '0;
        case (sh_phase)
            PH_HEADER: begin
                if (sh_hidx < 3'd4)
                    sh_code = {sh_code[23:0], b};
                else if (sh_hidx >= 3'd5)
                    sh_len = {sh_len[15:0], b};
                if (sh_hidx == 3'd7) begin
                    sh_hidx = 3'd0;
                    if (sh_len < HDR_BYTES) begin
                        sh_phase = PH_ERROR;
                        sh_err   = ST_LEN_SHORT;
                    end else begin
                        sh_left = sh_len - HDR_BYTES;
                        sh_pad  = 2'd0 - sh_len[1:0];
                        if (sh_left != 0)
                            sh_phase = PH_PAYLOAD;
                        else if (sh_pad != 0)
                            sh_phase = PH_PAD;
                        else
                            sh_phase = PH_HEADER;
                    end
                end else begin
                    sh_hidx = sh_hidx + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                r.payload_valid    = 1'b1;
                r.payload_byte     = b;
                r.avp_code         = sh_code;
                r.avp_class        = code_class(sh_code);
                r.first_of_payload = (sh_left == sh_len - HDR_BYTES);
                if (sh_left != 0)
                    sh_left = sh_left - 24'd1;
                if (sh_left == 0) begin
                    r.last_of_payload = 1'b1;
                    sh_phase = (sh_pad != 0) ? PH_PAD : PH_HEADER;
                end
            end
            PH_PAD: begin
                if (sh_pad != 0)
                    sh_pad = sh_pad - 2'd1;
                if (sh_pad == 0)
                    sh_phase = PH_HEADER;
            end
            default: ;
        endcase
        if (last) begin
            r.record_done = 1'b1;
            if (sh_phase == PH_ERROR)
                r.record_status = sh_err;
            else if (sh_phase == PH_HEADER && sh_hidx != 0)
                r.record_status = ST_HDR_TRUNC;
            else if (sh_phase == PH_PAYLOAD)
                r.record_status = ST_PAY_TRUNC;
            else
                r.record_status = ST_OK;
            clear_parser();
        end
        if (r.payload_valid || last)
            expected_beats.push_back(r);
    endtask

    // ---------------- stimulus builders ----------------
    task automatic add_header(input logic [31:0] code, input logic [23:0] len);
        rec_buf.push_back(code[31:24]);
        rec_buf.push_back(code[23:16]);
        rec_buf.push_back(code[15:8]);
        rec_buf.push_back(code[7:0]);
        rec_buf.push_back(8'($urandom));   // flags, ignored
        rec_buf.push_back(len[23:16]);
        rec_buf.push_back(len[15:8]);
        rec_buf.push_back(len[7:0]);
    endtask

    task automatic add_fill(input int n);
        for (int i = 0; i < n; i++)
            rec_buf.push_back(8'($urandom));
    endtask

    // well-formed pair: header, body payload bytes, then padding to 4
    task automatic add_pair(input logic [31:0] code, input int body);
        add_header(code, 24'(body + 8));
        add_fill(body);
        add_fill((4 - body % 4) % 4);
    endtask

    // queue the first keep bytes of the record buffer, last one marked
    task automatic send_record(input int keep);
        rec_byte_t t;
        for (int i = 0; i < keep; i++) begin
            t.data  = rec_buf[i];
            t.last  = (i == keep - 1);
            t.gap   = $urandom_range(0, gap_max);
            t.drain = drain_next && (i == 0);
            tx_bytes.push_back(t);
        end
        drain_next = 1'b0;
        rec_buf.delete();
    endtask

    function automatic logic [31:0] pick_code();
        case ($urandom_range(0, 5))
            0:       return CODE_EAP;
            1:       return CODE_AUTH;
            2:       return CODE_STATE;
            3:       return CODE_EAP | (32'd1 << $urandom_range(8, 31));
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_body();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 200);
        return $urandom_range(0, 24);
    endfunction

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            idle_cnt <= 0;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_data_byte, s_last_in_record);
                sent_cnt = sent_cnt + 1;
            end
            if (!s_valid || s_ready) begin
                if (tx_bytes.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (idle_cnt < tx_bytes[0].gap ||
                             (tx_bytes[0].drain && expected_beats.size() != 0)) begin
                    s_valid  <= 1'b0;
                    idle_cnt <= idle_cnt + 1;
                end else begin
                    s_valid          <= 1'b1;
                    s_data_byte      <= tx_bytes[0].data;
                    s_last_in_record <= tx_bytes[0].last;
                    void'(tx_bytes.pop_front());
                    idle_cnt         <= 0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got.payload_byte     = m_payload_byte;
                got.payload_valid    = m_payload_valid;
                got.avp_class        = avp_class_t'(m_avp_class);
                got.avp_code         = m_avp_code;
                got.first_of_payload = m_first_of_payload;
                got.last_of_payload  = m_last_of_payload;
                got.record_done      = m_record_done;
                got.record_status    = rec_status_t'(m_record_status);
                beat_cnt = beat_cnt + 1;
                if (expected_beats.size() == 0) begin
                    fail_cnt = fail_cnt + 1;
                    if (fail_cnt <= 10)
                        $display("beat %0d: unexpected, got %h", beat_cnt, got);
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        fail_cnt = fail_cnt + 1;
                        if (fail_cnt <= 10) begin
                            $display("beat %0d mismatch", beat_cnt);
                            $display("  exp byte=%h v=%b cls=%0d code=%h f=%b l=%b",
                                     want.payload_byte, want.payload_valid,
                                     want.avp_class, want.avp_code,
                                     want.first_of_payload, want.last_of_payload);
                            $display("      done=%b st=%0d",
                                     want.record_done, want.record_status);
                            $display("  got byte=%h v=%b cls=%0d code=%h f=%b l=%b",
                                     got.payload_byte, got.payload_valid,
                                     got.avp_class, got.avp_code,
                                     got.first_of_payload, got.last_of_payload);
                            $display("      done=%b st=%0d",
                                     got.record_done, got.record_status);
                        end
                    end
                end
                stall_draw = rx_calm ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 39) == 0)
                    rx_calm <= ~rx_calm;
                stall_left <= stall_draw;
                m_ready    <= (stall_draw == 0);
            end else if (stall_left != 0) begin
                // stall only counts down while a beat is offered
                if (m_valid) begin
                    stall_left <= stall_left - 1;
                    m_ready    <= (stall_left == 1);
                end
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        int base;
        int kind;
        int npairs;

        // lone byte: record cut right after the first header byte
        rec_buf.push_back(8'hFF);
        send_record(1);
        // EAP pair with one payload byte; record closes on its last padding byte
        add_pair(CODE_EAP, 1);
        send_record(rec_buf.size());
        // authenticator, then an empty state pair ending on its last header byte
        add_pair(CODE_AUTH, 4);
        add_pair(CODE_STATE, 0);
        send_record(rec_buf.size());
        // length 0: error, trailing bytes ignored
        add_header(32'h0000_0000, 24'd0);
        add_fill(5);
        send_record(rec_buf.size());
        // length 7 followed by a valid-looking pair that must be ignored
        add_header(32'hFFFF_FFFF, 24'd7);
        add_pair(CODE_EAP, 2);
        send_record(rec_buf.size());
        // maximum length, record cut inside the payload
        add_header(CODE_STATE, 24'hFF_FFFF);
        add_fill(3);
        send_record(rec_buf.size());
        // near-miss code; record ends on the last payload byte, no padding
        add_header(32'h0100_004F, 24'd12);
        add_fill(4);
        send_record(rec_buf.size());
        // record cut inside the second header
        add_pair(32'h0000_0000, 2);
        add_header(CODE_AUTH, 24'd20);
        send_record(rec_buf.size() - 3);

        drain_next = 1'b1;
        gap_max    = 7;
        base       = tx_bytes.size();
        while (tx_bytes.size() - base < 1250) begin
            if ($urandom_range(0, 7) == 0)
                gap_max = ($urandom_range(0, 1) != 0) ? 7 : 0;
            if ($urandom_range(0, 39) == 0)
                drain_next = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                npairs = $urandom_range(1, 4);
                for (int i = 0; i < npairs; i++)
                    add_pair(pick_code(), pick_body());
                if (kind < 60)
                    send_record(rec_buf.size());
                else
                    send_record($urandom_range(1, rec_buf.size()));
            end else if (kind < 87) begin
                if ($urandom_range(0, 1) != 0)
                    add_pair(pick_code(), pick_body());
                add_header(pick_code(), 24'($urandom_range(0, 7)));
                add_fill($urandom_range(0, 10));
                send_record(rec_buf.size());
            end else if (kind < 95) begin
                add_header(pick_code(), 24'($urandom_range(24'h000100, 24'hFFFFFF)));
                add_fill($urandom_range(1, 12));
                send_record(rec_buf.size());
            end else begin
                add_fill($urandom_range(1, 12));
                send_record(rec_buf.size());
            end
        end
        tx_total = tx_bytes.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // count accepted bytes so a byte popped but not yet taken is not missed
        while (sent_cnt < tx_total)
            @(posedge aclk);
        while (expected_beats.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (fail_cnt == 0 && expected_beats.size() == 0)
            $display("diameter_avp_stream_parser_core regression: pass");
        else
            $display("diameter_avp_stream_parser_core regression: fail");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("diameter_avp_stream_parser_core regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/davp_pkg.sv
rtl/core/davp_parse.sv
rtl/core/davp_out_reg.sv
rtl/core/diameter_avp_stream_parser_core.sv
bench/tb_top.sv
